// ----- hdl/toe_pkg.sv -----
`default_nettype none
package toe_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int HeldW = EdgeW + 1;
  localparam int CountW = NodeW + 1;
  localparam int DegW = HeldW;

  localparam logic ActAdd = 1'b0;
  localparam logic ActRun = 1'b1;

  // One result word as handed from the sequencer to the output register.
  typedef struct packed {
    logic             last;
    logic             fallback;
    logic [NodeW-1:0] position;
    logic [NodeW-1:0] node;
  } toe_result_t;
endpackage
`default_nettype wire

// ----- hdl/toe_edge_store.sv -----
`default_nettype none
module toe_edge_store (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [toe_pkg::EdgeW-1:0] wr_addr,
  input  wire logic [toe_pkg::NodeW-1:0] wr_source,
  input  wire logic [toe_pkg::NodeW-1:0] wr_target,
  input  wire logic [toe_pkg::EdgeW-1:0] rd_addr,
  output logic      [toe_pkg::NodeW-1:0] rd_source,
  output logic      [toe_pkg::NodeW-1:0] rd_target
);
  import toe_pkg::*;

  logic [2*NodeW-1:0] mem [MaxEdges];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_source, wr_target};
    end
    {rd_source, rd_target} <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hdl/toe_node_ram.sv -----
`default_nettype none
module toe_node_ram #(
  parameter int Width = 8
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [toe_pkg::NodeW-1:0] wr_addr,
  input  wire logic [Width-1:0]          wr_data,
  input  wire logic [toe_pkg::NodeW-1:0] rd_addr,
  output logic      [Width-1:0]          rd_data
);
  import toe_pkg::*;

  logic [Width-1:0] mem [MaxNodes];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hdl/toe_sequencer.sv -----
`default_nettype none
module toe_sequencer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [toe_pkg::CountW-1:0] n,
  input  wire logic [toe_pkg::HeldW-1:0]  held,
  output logic                            busy,
  output logic                            done,
  output logic      [toe_pkg::EdgeW-1:0]  edge_addr,
  input  wire logic [toe_pkg::NodeW-1:0]  edge_source,
  input  wire logic [toe_pkg::NodeW-1:0]  edge_target,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output toe_pkg::toe_result_t            res
);
  import toe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT_RD, S_CNT_WT, S_CNT_UPD, S_SEED, S_SEED_UPD,
    S_POP, S_POP_WT, S_WALK_RD, S_WALK_WT, S_WALK_UPD, S_EMIT_RD, S_EMIT_WT, S_EMIT
  } state_t;

  state_t state;
  logic [CountW-1:0] idx;       // node counter
  logic [HeldW-1:0]  eidx;      // edge counter
  logic [CountW-1:0] depth;
  logic [CountW-1:0] placed;
  logic [NodeW-1:0]  cur;
  logic              fallback;
  logic [NodeW-1:0]  es, et;

  // Shared node-indexed RAMs.
  logic              deg_we, stk_we, ord_we;
  logic [NodeW-1:0]  deg_wa, deg_ra, stk_wa, stk_ra, ord_wa, ord_ra;
  logic [DegW-1:0]   deg_wd, deg_rd;
  logic [NodeW-1:0]  stk_wd, stk_rd, ord_wd, ord_rd;

  toe_node_ram #(.Width(DegW)) u_deg (
    .clk, .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
    .rd_addr(deg_ra), .rd_data(deg_rd)
  );
  toe_node_ram #(.Width(NodeW)) u_stk (
    .clk, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_addr(stk_ra), .rd_data(stk_rd)
  );
  toe_node_ram #(.Width(NodeW)) u_ord (
    .clk, .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
    .rd_addr(ord_ra), .rd_data(ord_rd)
  );

  logic edge_ok;
  assign edge_ok = ({1'b0, es} < n) && ({1'b0, et} < n);
  assign busy = (state != S_IDLE);
  assign edge_addr = eidx[EdgeW-1:0];

  always_comb begin
    deg_we = 1'b0; deg_wa = idx[NodeW-1:0]; deg_wd = '0; deg_ra = et;
    stk_we = 1'b0; stk_wa = depth[NodeW-1:0]; stk_wd = idx[NodeW-1:0];
    stk_ra = depth[NodeW-1:0] - NodeW'(1);
    ord_we = 1'b0; ord_wa = placed[NodeW-1:0]; ord_wd = stk_rd;
    ord_ra = idx[NodeW-1:0];
    case (state)
      S_CLR: begin
        deg_we = 1'b1;
      end
      S_CNT_WT, S_WALK_WT: begin
        deg_ra = edge_target;
      end
      S_CNT_UPD: begin
        deg_we = edge_ok; deg_wa = et; deg_wd = deg_rd + DegW'(1);
      end
      S_SEED: begin
        deg_ra = idx[NodeW-1:0];
      end
      S_SEED_UPD: begin
        stk_we = (deg_rd == '0) && (depth < CountW'(MaxNodes));
      end
      S_POP_WT: begin
        ord_we = (placed < CountW'(MaxNodes));
      end
      S_WALK_UPD: begin
        deg_we = edge_ok && (es == cur) && (deg_rd != '0);
        deg_wa = et; deg_wd = deg_rd - DegW'(1);
        stk_we = deg_we && (deg_wd == '0) && (depth < CountW'(MaxNodes));
        stk_wd = et;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            idx <= '0;
            eidx <= '0;
            depth <= '0;
            placed <= '0;
            state <= (n == '0) ? S_IDLE : S_CLR;
            done <= (n == '0);
          end
        end
        S_CLR: begin
          idx <= idx + CountW'(1);
          if (idx + CountW'(1) == n) begin
            state <= (held == '0) ? S_SEED : S_CNT_RD;
            idx <= '0;
          end
        end
        S_CNT_RD: state <= S_CNT_WT;
        S_CNT_WT: begin
          es <= edge_source; et <= edge_target;
          state <= S_CNT_UPD;
        end
        S_CNT_UPD: begin
          // The degree read was issued from the store output in S_CNT_WT.
          state <= S_CNT_RD;
          eidx <= eidx + HeldW'(1);
          if (eidx + HeldW'(1) == held) begin
            state <= S_SEED;
            idx <= '0;
          end
        end
        S_SEED: state <= S_SEED_UPD;
        S_SEED_UPD: begin
          if ((deg_rd == '0) && (depth < CountW'(MaxNodes))) begin
            depth <= depth + CountW'(1);
          end
          idx <= idx + CountW'(1);
          state <= (idx + CountW'(1) == n) ? S_POP : S_SEED;
        end
        S_POP: begin
          if (depth == '0) begin
            fallback <= (placed != n);
            idx <= '0;
            state <= S_EMIT_RD;
          end else begin
            depth <= depth - CountW'(1);
            state <= S_POP_WT;
          end
        end
        S_POP_WT: begin
          cur <= stk_rd;
          if (placed < CountW'(MaxNodes)) begin
            placed <= placed + CountW'(1);
          end
          eidx <= '0;
          state <= (held == '0) ? S_POP : S_WALK_RD;
        end
        S_WALK_RD: state <= S_WALK_WT;
        S_WALK_WT: begin
          es <= edge_source; et <= edge_target;
          state <= S_WALK_UPD;
        end
        S_WALK_UPD: begin
          if (stk_we) begin
            depth <= depth + CountW'(1);
          end
          eidx <= eidx + HeldW'(1);
          state <= (eidx + HeldW'(1) == held) ? S_POP : S_WALK_RD;
        end
        S_EMIT_RD: state <= S_EMIT_WT;
        S_EMIT_WT: begin
          if (!res_valid || res_ready) begin
            res.node <= fallback ? idx[NodeW-1:0] : ord_rd;
            res.position <= idx[NodeW-1:0];
            res.fallback <= fallback;
            res.last <= (idx + CountW'(1) == n);
            res_valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          idx <= idx + CountW'(1);
          if (idx + CountW'(1) == n) begin
            state <= S_IDLE;
            done <= 1'b1;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/topological_order_engine.sv -----
// Channel   Dir  Handshake                Contents
// s_axis    in   s_axis_tvalid/tready     one edge, or a run request (tuser)
// m_axis    out  m_axis_tvalid/tready     one node of the order per word
// cfg       in   cfg_valid/cfg_ready      node_count register
//
// Edge loads are accepted back to back while the engine is idle. A run walks
// the edge store once to count in-degrees, then once per popped node, each
// edge visit going through the registered store read; each output word goes
// through its own read, wait and emit states plus any wait on m_axis_tready.
// The input and the configuration channel are not ready during a run, and the
// input stays not ready while the done pulse clears the edge count.
// Output words are held by the output register while m_axis_tready is low.
// rst is synchronous and active high; it empties the edge store.
`default_nettype none
module topological_order_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // edge_source[6:0], edge_target[13:7]
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // node_index[5:0], order_position[11:6],
                                           // cycle_fallback[12]
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data        // node_count[6:0]
);
  import toe_pkg::*;

  logic [6:0]        node_count;
  logic [CountW-1:0] n;
  logic [HeldW-1:0]  edges_held;
  logic              busy, done, start;
  logic [EdgeW-1:0]  rd_addr;
  logic [NodeW-1:0]  rd_source, rd_target;
  logic [6:0]        in_src, in_tgt;
  logic              add_ok;
  toe_result_t       res;

  // Node counts above capacity behave as full capacity.
  assign n = (node_count > 7'(MaxNodes)) ? CountW'(MaxNodes) : CountW'(node_count);
  assign cfg_ready = !busy;
  assign s_axis_tready = !busy && !done;
  assign in_src = s_axis_tdata[6:0];
  assign in_tgt = s_axis_tdata[13:7];
  assign start = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ActRun);
  assign add_ok = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ActAdd)
                  && ({1'b0, in_src} < 8'(n)) && ({1'b0, in_tgt} < 8'(n))
                  && (edges_held < HeldW'(MaxEdges));

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      edges_held <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data[6:0];
      end
      if (add_ok) begin
        edges_held <= edges_held + HeldW'(1);
      end else if (done) begin
        edges_held <= '0;
      end
    end
  end

  toe_edge_store u_store (
    .clk, .wr_en(add_ok), .wr_addr(edges_held[EdgeW-1:0]),
    .wr_source(in_src[NodeW-1:0]), .wr_target(in_tgt[NodeW-1:0]),
    .rd_addr, .rd_source, .rd_target
  );

  toe_sequencer u_seq (
    .clk, .rst, .start, .n, .held(edges_held), .busy, .done,
    .edge_addr(rd_addr), .edge_source(rd_source), .edge_target(rd_target),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {3'b000, res.fallback, res.position, res.node};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

// ----- hdl/toe_checker.sv -----
`default_nettype none
module toe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_nobusy_in: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready while emitting");
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("tlast changed under stall");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:13] == 3'b000)
    else $error("tdata padding not zero");
endmodule

bind topological_order_engine toe_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast
);
`default_nettype wire
